// ===== design/dcq_pkg.sv =====
`default_nettype none

package dcq_pkg;

    localparam logic [2:0] REQ_PUSH    = 3'd0;
    localparam logic [2:0] REQ_POP     = 3'd1;
    localparam logic [2:0] REQ_CANCEL  = 3'd2;
    localparam logic [2:0] REQ_RESTART = 3'd3;
    localparam logic [2:0] REQ_STAT    = 3'd4;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_REJECT   = 2'd1;
    localparam logic [1:0] STS_EMPTY    = 2'd2;
    localparam logic [1:0] STS_CANCELED = 2'd3;

    localparam int NUM_STATS = 9;
    localparam logic [3:0] STAT_ENQ_C  = 4'd0;
    localparam logic [3:0] STAT_ENQ_S  = 4'd1;
    localparam logic [3:0] STAT_DEQ_C  = 4'd2;
    localparam logic [3:0] STAT_DEQ_S  = 4'd3;
    localparam logic [3:0] STAT_DROP_C = 4'd4;
    localparam logic [3:0] STAT_DROP_S = 4'd5;
    localparam logic [3:0] STAT_CLR_C  = 4'd6;
    localparam logic [3:0] STAT_CLR_S  = 4'd7;
    localparam logic [3:0] STAT_REJ    = 4'd8;

    localparam int S_TDATA_W = 160;
    localparam int M_TDATA_W = 144;

    // classified request as handed from front to back
    typedef struct packed {
        logic [2:0]  req;
        logic [3:0]  sidx;
        logic        meta_ok;
        logic [20:0] count;
    } item_t;

    function automatic logic [63:0] sat_add(input logic [63:0] v, input logic [63:0] inc);
        logic [64:0] s;
        s = {1'b0, v} + {1'b0, inc};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    function automatic logic [6:0] sat7(input logic [31:0] v);
        return (v > 32'd127) ? 7'd127 : v[6:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/dcq_ram.sv =====
`default_nettype none

module dcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/dcq_front.sv =====
`default_nettype none

module dcq_front #(
    parameter int HANDLE_BITS = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [dcq_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [2:0]                      s_tuser,
    output logic                                 q_valid,
    input  wire logic                            q_take,
    output dcq_pkg::item_t                       q_item,
    output logic      [HANDLE_BITS-1:0]          q_hdl
);

    dcq_pkg::item_t         item_reg [2];
    logic [HANDLE_BITS-1:0] hdl_reg  [2];
    logic                   wptr_reg, wptr_next;
    logic                   rptr_reg, rptr_next;
    logic [1:0]             fill_reg, fill_next;

    dcq_pkg::item_t         cls;
    logic [HANDLE_BITS+15:0] hin;
    logic                   push;

    // metadata check: kind, rate, sign of start time, generation, nonzero count
    always_comb begin
        cls.req     = s_tuser;
        cls.count   = s_tdata[20:0];
        cls.sidx    = s_tdata[155:152];
        cls.meta_ok = (s_tdata[39:37] != 3'd0) && (s_tdata[71:40] != 32'd0) &&
                      !s_tdata[119] && (s_tdata[151:120] != 32'd0) &&
                      (s_tdata[20:0] != 21'd0);
        hin         = {{HANDLE_BITS{1'b0}}, s_tdata[36:21]};
    end

    assign s_tready = (fill_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = item_reg[rptr_reg];
    assign q_hdl    = hdl_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ (q_take && q_valid);
        fill_next = fill_reg + {1'b0, push} - {1'b0, q_take && q_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
        if (push) begin
            item_reg[wptr_reg] <= cls;
            hdl_reg[wptr_reg]  <= hin[HANDLE_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== design/dcq_back.sv =====
`default_nettype none

module dcq_back #(
    parameter int QUEUE_DEPTH  = 64,
    parameter int SAMPLE_LIMIT = 1048576,
    parameter int HANDLE_BITS  = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_addr,
    input  wire logic [20:0]                   cfg_wdata,
    input  wire logic                          q_valid,
    output logic                               q_take,
    input  wire dcq_pkg::item_t                q_item,
    input  wire logic [HANDLE_BITS-1:0]        q_hdl,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [dcq_pkg::M_TDATA_W-1:0] m_tdata,
    output logic      [1:0]                    m_tuser
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int DW = HANDLE_BITS + 21;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DROP = 2'd2;
    localparam logic [1:0] ST_POPD = 2'd3;

    logic [1:0]             state_reg, state_next;
    dcq_pkg::item_t         cur_reg, cur_next;
    logic [HANDLE_BITS-1:0] hdl_reg, hdl_next;
    logic [AW-1:0]          head_reg, head_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [20:0]            tot_reg, tot_next;
    logic                   cxl_reg, cxl_next;
    logic [CW-1:0]          drop_reg, drop_next;
    logic [6:0]             mc_reg;
    logic [20:0]            ms_reg;
    logic [63:0]            stats_reg [dcq_pkg::NUM_STATS];
    logic [63:0]            stats_next [dcq_pkg::NUM_STATS];
    logic [63:0]            stat_inc [dcq_pkg::NUM_STATS];
    logic                   mvalid_reg, mvalid_next;
    logic [dcq_pkg::M_TDATA_W-1:0] mdata_reg, mdata_next;
    logic [1:0]             muser_reg, muser_next;

    logic [CW-1:0]          cap;
    logic [20:0]            budget;
    logic                   out_free;
    logic                   rejected, need_drop;
    logic [CW:0]            tail_sum, tail_wrap;
    logic [AW-1:0]          tail;
    logic [AW:0]            head_inc;
    logic [DW-1:0]          rd_data;
    logic [20:0]            th_cnt, th_tot;
    logic [HANDLE_BITS-1:0] th_hdl;
    logic [CW-1:0]          th_entries;
    logic [AW-1:0]          th_head;
    logic                   ram_we;
    logic                   emit;
    logic [1:0]             o_status;
    logic [HANDLE_BITS+15:0] o_hx;
    logic [20:0]            o_cnt;
    logic [63:0]            o_stat;

    dcq_ram #(.WIDTH(DW), .DEPTH(QUEUE_DEPTH)) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (tail),
        .wdata ({hdl_reg, cur_reg.count}),
        .raddr (head_reg),
        .rdata (rd_data)
    );

    always_comb begin
        if (mc_reg == 7'd0) begin
            cap = CW'(1);
        end else if (32'(mc_reg) > 32'(QUEUE_DEPTH)) begin
            cap = CW'(QUEUE_DEPTH);
        end else begin
            cap = CW'(mc_reg);
        end
        if (ms_reg == 21'd0) begin
            budget = 21'd1;
        end else if (32'(ms_reg) > 32'(SAMPLE_LIMIT)) begin
            budget = 21'(SAMPLE_LIMIT);
        end else begin
            budget = ms_reg;
        end
    end

    // head removal, used by both drop and pop
    always_comb begin
        th_cnt     = rd_data[20:0];
        th_hdl     = rd_data[DW-1:21];
        th_tot     = (th_cnt > tot_reg) ? 21'd0 : tot_reg - th_cnt;
        th_entries = cnt_reg - CW'(1);
        head_inc   = {1'b0, head_reg} + (AW+1)'(1);
        if (th_entries == '0 || head_inc >= (AW+1)'(QUEUE_DEPTH)) begin
            th_head = '0;
        end else begin
            th_head = head_inc[AW-1:0];
        end
        tail_sum  = (CW+1)'(head_reg) + (CW+1)'(cnt_reg);
        tail_wrap = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                    tail_sum - (CW+1)'(QUEUE_DEPTH) : tail_sum;
        tail      = tail_wrap[AW-1:0];
    end

    assign out_free  = !mvalid_reg || m_tready;
    assign rejected  = !cur_reg.meta_ok || (cur_reg.count > budget) || cxl_reg;
    assign need_drop = (cnt_reg != '0) &&
                       ((cnt_reg >= cap) ||
                        ({1'b0, tot_reg} + {1'b0, cur_reg.count} > {1'b0, budget}));

    always_comb begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        hdl_next    = hdl_reg;
        head_next   = head_reg;
        cnt_next    = cnt_reg;
        tot_next    = tot_reg;
        cxl_next    = cxl_reg;
        drop_next   = drop_reg;
        q_take      = 1'b0;
        ram_we      = 1'b0;
        emit        = 1'b0;
        o_status    = dcq_pkg::STS_OK;
        o_hx        = '0;
        o_cnt       = 21'd0;
        o_stat      = 64'd0;
        for (int i = 0; i < dcq_pkg::NUM_STATS; i++) begin
            stat_inc[i] = 64'd0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_take     = 1'b1;
                    cur_next   = q_item;
                    hdl_next   = q_hdl;
                    drop_next  = '0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    case (cur_reg.req)
                        dcq_pkg::REQ_PUSH: begin
                            if (rejected) begin
                                stat_inc[dcq_pkg::STAT_REJ] = 64'd1;
                                o_status = dcq_pkg::STS_REJECT;
                                emit     = 1'b1;
                            end else if (need_drop) begin
                                state_next = ST_DROP;
                            end else begin
                                ram_we   = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                                tot_next = tot_reg + cur_reg.count;
                                stat_inc[dcq_pkg::STAT_ENQ_C] = 64'd1;
                                stat_inc[dcq_pkg::STAT_ENQ_S] = 64'(cur_reg.count);
                                emit     = 1'b1;
                            end
                        end
                        dcq_pkg::REQ_POP: begin
                            if (cxl_reg) begin
                                o_status = dcq_pkg::STS_CANCELED;
                                emit     = 1'b1;
                            end else if (cnt_reg == '0) begin
                                o_status = dcq_pkg::STS_EMPTY;
                                emit     = 1'b1;
                            end else begin
                                state_next = ST_POPD;
                            end
                        end
                        dcq_pkg::REQ_CANCEL, dcq_pkg::REQ_RESTART: begin
                            // total equals the sum of held counts, so one bulk add
                            stat_inc[dcq_pkg::STAT_CLR_C] = 64'(cnt_reg);
                            stat_inc[dcq_pkg::STAT_CLR_S] = 64'(tot_reg);
                            cnt_next  = '0;
                            tot_next  = 21'd0;
                            head_next = '0;
                            cxl_next  = (cur_reg.req == dcq_pkg::REQ_CANCEL);
                            emit      = 1'b1;
                        end
                        dcq_pkg::REQ_STAT: begin
                            if (32'(cur_reg.sidx) < 32'(dcq_pkg::NUM_STATS)) begin
                                o_stat = stats_reg[cur_reg.sidx];
                            end
                            emit = 1'b1;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_DROP: begin
                head_next = th_head;
                cnt_next  = th_entries;
                tot_next  = th_tot;
                drop_next = drop_reg + CW'(1);
                stat_inc[dcq_pkg::STAT_DROP_C] = 64'd1;
                stat_inc[dcq_pkg::STAT_DROP_S] = 64'(th_cnt);
                state_next = ST_EXEC;
            end
            ST_POPD: begin
                head_next = th_head;
                cnt_next  = th_entries;
                tot_next  = th_tot;
                stat_inc[dcq_pkg::STAT_DEQ_C] = 64'd1;
                stat_inc[dcq_pkg::STAT_DEQ_S] = 64'(th_cnt);
                o_hx      = {16'd0, th_hdl};
                o_cnt     = th_cnt;
                emit      = 1'b1;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit) begin
            state_next = ST_IDLE;
        end

        for (int i = 0; i < dcq_pkg::NUM_STATS; i++) begin
            stats_next[i] = dcq_pkg::sat_add(stats_reg[i], stat_inc[i]);
        end

        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;
        if (emit) begin
            mvalid_next = 1'b1;
            muser_next  = o_status;
            mdata_next  = {7'd0, o_stat, cxl_next, tot_next,
                           dcq_pkg::sat7(32'(cnt_next)),
                           dcq_pkg::sat7((cur_reg.req == dcq_pkg::REQ_PUSH) ?
                                         32'(drop_reg) : 32'd0),
                           o_cnt, o_hx[15:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            cnt_reg    <= '0;
            tot_reg    <= 21'd0;
            cxl_reg    <= 1'b0;
            drop_reg   <= '0;
            mvalid_reg <= 1'b0;
            mc_reg     <= 7'd64;
            ms_reg     <= 21'd1048576;
            for (int i = 0; i < dcq_pkg::NUM_STATS; i++) begin
                stats_reg[i] <= 64'd0;
            end
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            cnt_reg    <= cnt_next;
            tot_reg    <= tot_next;
            cxl_reg    <= cxl_next;
            drop_reg   <= drop_next;
            mvalid_reg <= mvalid_next;
            for (int i = 0; i < dcq_pkg::NUM_STATS; i++) begin
                stats_reg[i] <= stats_next[i];
            end
            if (cfg_we) begin
                if (cfg_addr) begin
                    ms_reg <= cfg_wdata;
                end else begin
                    mc_reg <= cfg_wdata[6:0];
                end
            end
        end
        cur_reg   <= cur_next;
        hdl_reg   <= hdl_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

endmodule

`default_nettype wire

// ===== design/drop_oldest_chunk_queue.sv =====
// Bounded drop-oldest queue of audio chunk descriptors (handle + sample count).
// Input stream (s_*): one request per transaction, s_tuser = request type
// (push, pop, cancel, restart, read statistic), s_tdata = descriptor fields.
// Output stream (m_*): exactly one result per request, in request order,
// m_tuser = status, m_tdata = popped entry, drop count, fill and statistic.
// Configuration: cfg_we/cfg_addr/cfg_wdata set chunk capacity (0) and sample
// budget (1); write only while the block is idle.
// Requests pass through a two-entry front queue into the execute sequencer.
// Each request passes the front queue, a load state, an execute state and the
// output register; a successful pop adds a removal state because the slot
// memory has a registered read, and each oldest entry a push drops adds a
// removal state and a return to execute. The sequencer loads the next request
// only after emitting a result, and waits in execute while a result is stalled.
// Slot memory needs no clearing; reset empties the queue, clears the
// cancelled flag and all statistics, and restores register defaults.
// When m_tready is low the result stays in the output register; the front
// queue keeps accepting until its two entries fill, then s_tready drops.
`default_nettype none

module drop_oldest_chunk_queue #(
    parameter int QUEUE_DEPTH  = 64,
    parameter int SAMPLE_LIMIT = 1048576,
    parameter int HANDLE_BITS  = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_addr,
    input  wire logic [20:0]                   cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // sample_count, chunk_handle, source_kind, sample_rate, start_time,
    // generation, stat_index
    input  wire logic [dcq_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type
    input  wire logic [2:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // out_handle, out_sample_count, dropped_now, queued_chunks,
    // queued_samples, cancelled_flag, stat_value
    output logic      [dcq_pkg::M_TDATA_W-1:0] m_tdata,
    // status
    output logic      [1:0]                    m_tuser
);

    logic                   q_valid;
    logic                   q_take;
    dcq_pkg::item_t         q_item;
    logic [HANDLE_BITS-1:0] q_hdl;

    dcq_front #(.HANDLE_BITS(HANDLE_BITS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_take   (q_take),
        .q_item   (q_item),
        .q_hdl    (q_hdl)
    );

    dcq_back #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .SAMPLE_LIMIT (SAMPLE_LIMIT),
        .HANDLE_BITS  (HANDLE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_take    (q_take),
        .q_item    (q_item),
        .q_hdl     (q_hdl),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== design/dcq_checker.sv =====
`default_nettype none

module dcq_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [143:0] m_tdata,
    input wire logic [1:0]   m_tuser
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == dcq_pkg::STS_EMPTY |-> m_tdata[50:44] == 7'd0 &&
                                                       !m_tdata[72])
        else $error("empty pop with chunks held");

    a_cancel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == dcq_pkg::STS_CANCELED |-> m_tdata[72] &&
                                                          m_tdata[50:44] == 7'd0)
        else $error("cancelled pop without cancelled empty queue");

    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[43:37] != 7'd0 |-> m_tuser == dcq_pkg::STS_OK &&
                                                m_tdata[50:44] != 7'd0)
        else $error("drops reported on a non-admitted request");

endmodule

bind drop_oldest_chunk_queue dcq_checker u_dcq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/dcq_checker.sv =====
`default_nettype none

module dcq_scoreboard (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic         cfg_addr,
    input  wire logic [20:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [159:0] s_tdata,
    input  wire logic [2:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [143:0] m_tdata,
    input  wire logic [1:0]   m_tuser,
    output int                n_errors,
    output int                n_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int LIMIT = 1048576;

    typedef struct packed {
        logic [1:0]   status;
        logic [143:0] data;
    } outcome_t;

    logic [6:0]  cap_reg;
    logic [20:0] budget_reg;
    logic [15:0] q_handle [DEPTH];
    logic [20:0] q_count [DEPTH];
    int          q_head, q_fill, q_samples;
    bit          q_cancelled;
    logic [63:0] counters [dcq_pkg::NUM_STATS];
    outcome_t    expected_q [$];

    function automatic logic [63:0] bump(logic [63:0] v, logic [63:0] inc);
        logic [64:0] s;
        s = {1'b0, v} + {1'b0, inc};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic int pop_head(output logic [15:0] h);
        int c;
        c = q_count[q_head];
        h = q_handle[q_head];
        q_samples = (c > q_samples) ? 0 : q_samples - c;
        q_head = (q_head + 1) % DEPTH;
        q_fill--;
        if (q_fill == 0) q_head = 0;
        return c;
    endfunction

    function automatic void flush_queue();
        logic [15:0] h;
        int c;
        while (q_fill != 0) begin
            c = pop_head(h);
            counters[dcq_pkg::STAT_CLR_C] = bump(counters[dcq_pkg::STAT_CLR_C], 1);
            counters[dcq_pkg::STAT_CLR_S] = bump(counters[dcq_pkg::STAT_CLR_S], c);
        end
    endfunction

    function automatic outcome_t predict_result(logic [2:0] req, logic [159:0] d);
        logic [20:0] count;
        logic [15:0] handle, h;
        logic [2:0]  kind;
        logic [31:0] rate, gen;
        logic [47:0] t0;
        logic [3:0]  sidx;
        logic [1:0]  status;
        logic [15:0] oh;
        logic [20:0] oc;
        logic [63:0] stat;
        int cap, budget, dropped, c, tail;
        outcome_t r;
        {sidx, gen, t0, rate, kind, handle, count} = d[155:0];
        status = dcq_pkg::STS_OK; oh = 0; oc = 0; stat = 0; dropped = 0;
        cap = (cap_reg == 0) ? 1 : (cap_reg > DEPTH ? DEPTH : cap_reg);
        budget = (budget_reg == 0) ? 1 : (budget_reg > LIMIT ? LIMIT : budget_reg);
        case (req)
            dcq_pkg::REQ_PUSH: begin
                if (kind == 0 || rate == 0 || t0[47] || gen == 0 || count == 0 ||
                    count > budget || q_cancelled) begin
                    counters[dcq_pkg::STAT_REJ] = bump(counters[dcq_pkg::STAT_REJ], 1);
                    status = dcq_pkg::STS_REJECT;
                end else begin
                    while (q_fill != 0 && (q_fill >= cap || q_samples + count > budget)) begin
                        c = pop_head(h);
                        counters[dcq_pkg::STAT_DROP_C] =
                            bump(counters[dcq_pkg::STAT_DROP_C], 1);
                        counters[dcq_pkg::STAT_DROP_S] =
                            bump(counters[dcq_pkg::STAT_DROP_S], c);
                        dropped++;
                    end
                    tail = (q_head + q_fill) % DEPTH;
                    q_handle[tail] = handle;
                    q_count[tail] = count;
                    q_fill++;
                    q_samples += count;
                    counters[dcq_pkg::STAT_ENQ_C] = bump(counters[dcq_pkg::STAT_ENQ_C], 1);
                    counters[dcq_pkg::STAT_ENQ_S] =
                        bump(counters[dcq_pkg::STAT_ENQ_S], count);
                end
            end
            dcq_pkg::REQ_POP: begin
                if (q_cancelled) status = dcq_pkg::STS_CANCELED;
                else if (q_fill == 0) status = dcq_pkg::STS_EMPTY;
                else begin
                    c = pop_head(h);
                    oh = h; oc = c;
                    counters[dcq_pkg::STAT_DEQ_C] = bump(counters[dcq_pkg::STAT_DEQ_C], 1);
                    counters[dcq_pkg::STAT_DEQ_S] = bump(counters[dcq_pkg::STAT_DEQ_S], c);
                end
            end
            dcq_pkg::REQ_CANCEL: begin
                flush_queue();
                q_cancelled = 1;
            end
            dcq_pkg::REQ_RESTART: begin
                flush_queue();
                q_cancelled = 0;
            end
            dcq_pkg::REQ_STAT: if (sidx < dcq_pkg::NUM_STATS) stat = counters[sidx];
            default: ;
        endcase
        r.status = status;
        r.data = {7'd0, stat, q_cancelled, q_samples[20:0],
                  (q_fill > 127) ? 7'd127 : q_fill[6:0],
                  (dropped > 127) ? 7'd127 : dropped[6:0], oc, oh};
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [143:0] got, logic [143:0] want);
        $display("%0t: mismatch %s: got %h want %h", $realtime, what, got, want);
        n_errors++;
    endtask

    initial begin
        n_errors = 0;
        n_pending = 0;
    end

    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            cap_reg <= 7'd64;
            budget_reg <= 21'd1048576;
            q_head = 0; q_fill = 0; q_samples = 0; q_cancelled = 0;
            for (int i = 0; i < dcq_pkg::NUM_STATS; i++) counters[i] = 0;
            expected_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_addr == 1'b0) cap_reg <= cfg_wdata[6:0];
                else budget_reg <= cfg_wdata;
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(predict_result(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected transaction", m_tdata, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", m_tuser, want.status);
                    if (m_tdata[15:0] !== want.data[15:0])
                        report_mismatch("out_handle", m_tdata[15:0], want.data[15:0]);
                    if (m_tdata[36:16] !== want.data[36:16])
                        report_mismatch("out_sample_count", m_tdata[36:16], want.data[36:16]);
                    if (m_tdata[43:37] !== want.data[43:37])
                        report_mismatch("dropped_now", m_tdata[43:37], want.data[43:37]);
                    if (m_tdata[50:44] !== want.data[50:44])
                        report_mismatch("queued_chunks", m_tdata[50:44], want.data[50:44]);
                    if (m_tdata[71:51] !== want.data[71:51])
                        report_mismatch("queued_samples", m_tdata[71:51], want.data[71:51]);
                    if (m_tdata[72] !== want.data[72])
                        report_mismatch("cancelled_flag", m_tdata[72], want.data[72]);
                    if (m_tdata[136:73] !== want.data[136:73])
                        report_mismatch("stat_value", m_tdata[136:73], want.data[136:73]);
                end
            end
        end
        n_pending = expected_q.size();
    end
endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic         aclk, aresetn;
    logic         cfg_we, cfg_addr;
    logic [20:0]  cfg_wdata;
    logic         s_tvalid, s_tready;
    // sample_count, chunk_handle, source_kind, sample_rate, start_time,
    // generation, stat_index
    logic [159:0] s_tdata;
    // req_type
    logic [2:0]   s_tuser;
    logic         m_tvalid, m_tready;
    // out_handle, out_sample_count, dropped_now, queued_chunks,
    // queued_samples, cancelled_flag, stat_value
    logic [143:0] m_tdata;
    // status
    logic [1:0]   m_tuser;
    int           n_errors, n_pending;
    bit           calm;

    drop_oldest_chunk_queue u_top (.*);

    dcq_scoreboard u_chk (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("FAIL");
        $finish;
    end

    // receiver stalls in bursts
    initial begin
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            m_tready <= 1;
        end
    end

    // s_tvalid stays high after a transaction; callers that pause drop it
    task automatic send(logic [2:0] req, logic [20:0] cnt, logic [15:0] hdl,
                        logic [2:0] kind, logic [31:0] rate, logic [47:0] t0,
                        logic [31:0] gen, logic [3:0] sidx);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= req;
        s_tdata <= {4'd0, sidx, gen, t0, rate, kind, hdl, cnt};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_push(logic [20:0] cnt);
        send(dcq_pkg::REQ_PUSH, cnt, 16'($urandom), 3'($urandom_range(1, 7)),
             $urandom_range(1, 32'hFFFFFFFF), {1'b0, 47'({$urandom, $urandom})},
             $urandom_range(1, 32'hFFFFFFFF), 4'($urandom));
    endtask

    task automatic write_reg(logic idx, logic [20:0] v);
        cfg_we <= 1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (n_pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    function automatic logic [20:0] pick_count(int budget);
        case ($urandom_range(0, 9))
            0: return 21'($urandom_range(0, 3));
            1: return 21'(budget);
            2: return 21'(budget + 1);
            3: return 21'($urandom);
            default: return 21'($urandom_range(1, budget > 1 ? budget : 1));
        endcase
    endfunction

    initial begin
        int budget;
        logic [20:0] cnt;
        int r;
        calm = 0;
        aresetn = 0; cfg_we = 0; cfg_addr = 0; cfg_wdata = 0;
        s_tvalid = 0; s_tdata = 0; s_tuser = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, every request type, invalid metadata
        send(dcq_pkg::REQ_POP, 0, 0, 0, 0, 0, 0, 0);
        send_push(21'd1048576);
        send_push(21'd1);
        send(dcq_pkg::REQ_PUSH, 21'h1FFFFF, 16'hFFFF, 3'd7, '1, 48'h7FFFFFFFFFFF, '1, 4'hF);
        send(dcq_pkg::REQ_PUSH, 0, 16'hFFFF, 3'd7, '1, 48'd5, '1, 0);
        send(dcq_pkg::REQ_PUSH, 10, 16'h1234, 3'd0, '1, 48'd5, '1, 0);
        send(dcq_pkg::REQ_PUSH, 10, 16'h1234, 3'd1, 0, 48'd5, '1, 0);
        send(dcq_pkg::REQ_PUSH, 10, 16'h1234, 3'd1, 1, 48'h800000000000, '1, 0);
        send(dcq_pkg::REQ_PUSH, 10, 16'h1234, 3'd1, 1, 48'd0, 0, 0);
        send(dcq_pkg::REQ_PUSH, 10, 16'hFFFF, 3'd7, '1, 48'd0, 1, 0);
        send(dcq_pkg::REQ_POP, 0, 0, 0, 0, 0, 0, 0);
        send(dcq_pkg::REQ_CANCEL, 0, 0, 0, 0, 0, 0, 0);
        send_push(21'd5);
        send(dcq_pkg::REQ_PUSH, 0, 0, 0, 0, 0, 0, 0);
        send(dcq_pkg::REQ_POP, 0, 0, 0, 0, 0, 0, 0);
        send(dcq_pkg::REQ_RESTART, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 10; i++) send(dcq_pkg::REQ_STAT, '1, '1, '1, '1, '1, '1, 4'(i));
        send(3'd5, 0, 0, 0, 0, 0, 0, 0);
        send(3'd7, '1, '1, '1, '1, '1, '1, '1);
        drain();

        // phases over register settings, extremes included
        for (int ph = 0; ph < 10; ph++) begin
            logic [6:0]  cap;
            logic [20:0] bud;
            case (ph)
                0: begin cap = 0; bud = 0; end
                1: begin cap = 1; bud = 21'd1048576; end
                2: begin cap = 7'd127; bud = 21'h1FFFFF; end
                3: begin cap = 64; bud = 1; end
                4: begin cap = 65; bud = 21'd1048577; end
                default: begin
                    cap = 7'($urandom_range(1, 70));
                    bud = ($urandom_range(0, 1)) ? 21'($urandom_range(1, 300))
                                                 : 21'($urandom);
                end
            endcase
            write_reg(1'b0, {14'd0, cap});
            write_reg(1'b1, bud);
            budget = (bud == 0) ? 1 : (bud > 1048576 ? 1048576 : bud);
            if (ph == 9) calm = 1;
            for (int i = 0; i < 190; i++) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    send_push(pick_count(budget));
                end else if (r < 60) begin
                    send($urandom_range(0, 1) ? dcq_pkg::REQ_PUSH
                                              : 3'($urandom_range(5, 7)),
                         21'($urandom), 16'($urandom), 3'($urandom), $urandom,
                         48'({$urandom, $urandom}), $urandom_range(0, 1) ? 0 : $urandom,
                         4'($urandom));
                end else if (r < 85) begin
                    send(dcq_pkg::REQ_POP, 0, 0, 0, 0, 0, 0, 0);
                end else if (r < 88) begin
                    send(dcq_pkg::REQ_CANCEL, 0, 0, 0, 0, 0, 0, 0);
                end else if (r < 93) begin
                    send(dcq_pkg::REQ_RESTART, 0, 0, 0, 0, 0, 0, 0);
                end else begin
                    send(dcq_pkg::REQ_STAT, 0, 0, 0, 0, 0, 0, 4'($urandom_range(0, 15)));
                end
                // hold off until the queue of results has emptied
                if (i == 95) begin
                    s_tvalid <= 0;
                    @(posedge aclk);
                    while (n_pending != 0) @(posedge aclk);
                end
            end
            drain();
        end

        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire
